@@ src/http_request_line_parser_macros.svh @@
// ----------------------------------------------------------------------------
// HTTP request line parser - assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

// same-cycle implication
`define HRLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, character constants and extension tables of the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int MAX_FIELDS     = 16;
    localparam int MAX_METHOD_LEN = 10;

    localparam logic [3:0] FIELD_LAST   = 4'(MAX_FIELDS - 1);
    localparam logic [3:0] METHOD_LIMIT = 4'(MAX_METHOD_LEN);
    localparam logic [3:0] METHOD_SAT   = 4'd15;
    localparam logic [3:0] GET_LEN      = 4'd3;
    localparam logic [2:0] RES_LEN_SAT  = 3'd4;
    localparam logic [2:0] EXT_LEN_SAT  = 3'd5;
    localparam logic [2:0] EXT_STORE    = 3'd4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [7:0] GET_WORD [3] = '{8'h47, 8'h45, 8'h54};

    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_SLASH    = 3'd1,
        PH_RESOURCE = 3'd2,
        PH_QUERY    = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_METHOD    = 3'd0,
        ROLE_SKIP      = 3'd1,
        ROLE_RESOURCE  = 3'd2,
        ROLE_QUERY     = 3'd3,
        ROLE_FIELD     = 3'd4,
        ROLE_SEPARATOR = 3'd5,
        ROLE_LINE_END  = 3'd6,
        ROLE_IGNORED   = 3'd7
    } role_t;

    typedef enum logic [3:0] {
        MIME_NONE = 4'd0,
        MIME_HTML = 4'd1,
        MIME_CSS  = 4'd2,
        MIME_JS   = 4'd3,
        MIME_BMP  = 4'd4,
        MIME_JPEG = 4'd5,
        MIME_PNG  = 4'd6,
        MIME_WEBP = 4'd7,
        MIME_ICO  = 4'd8
    } mime_t;

    localparam int EXT_ENTRIES = 9;

    localparam logic [7:0] EXT_TEXT [EXT_ENTRIES][4] = '{
        '{8'h68, 8'h74, 8'h6D, 8'h6C},  // html
        '{8'h63, 8'h73, 8'h73, 8'h00},  // css
        '{8'h6A, 8'h73, 8'h00, 8'h00},  // js
        '{8'h62, 8'h6D, 8'h70, 8'h00},  // bmp
        '{8'h6A, 8'h70, 8'h65, 8'h67},  // jpeg
        '{8'h6A, 8'h70, 8'h67, 8'h00},  // jpg
        '{8'h70, 8'h6E, 8'h67, 8'h00},  // png
        '{8'h77, 8'h65, 8'h62, 8'h70},  // webp
        '{8'h69, 8'h63, 8'h6F, 8'h00}   // ico
    };

    localparam logic [2:0] EXT_LEN [EXT_ENTRIES] =
        '{3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3};

    localparam mime_t EXT_CODE [EXT_ENTRIES] = '{MIME_HTML, MIME_CSS, MIME_JS,
        MIME_BMP, MIME_JPEG, MIME_JPEG, MIME_PNG, MIME_WEBP, MIME_ICO};

    typedef struct packed {
        logic [7:0] req_byte;
        logic       start_of_request;
    } req_t;

    typedef struct packed {
        role_t       byte_role;
        logic [3:0]  field_index;
        logic        line_done;
        logic        is_get;
        logic        resource_empty;
        logic        client_side;
        mime_t       mime_code;
        logic [4:0]  field_count;
        logic        field_overflow;
    } rsp_t;

    // resource summary handed to the extension matcher
    typedef struct packed {
        logic [2:0]       res_len;
        logic             dot_seen;
        logic             last_dot_at_start;
        logic [2:0]       ext_len;
        logic [3:0][7:0]  ext_chars;
    } ext_info_t;

endpackage

@@ src/hrlp_mime.sv @@
// ----------------------------------------------------------------------------
// hrlp_mime
// Matches the lowercased last extension of the resource against the table.
// ----------------------------------------------------------------------------
module hrlp_mime (
    input  hrlp_pkg::ext_info_t ext,
    output hrlp_pkg::mime_t     code
);
    import hrlp_pkg::*;

    logic [EXT_ENTRIES-1:0] hit;

    always_comb
    begin
        hit = '0;
        for (int k = 0; k < EXT_ENTRIES; k++)
        begin
            hit[k] = (EXT_LEN[k] == ext.ext_len);
            for (int p = 0; p < 4; p++)
            begin
                if (3'(p) < ext.ext_len && ext.ext_chars[p] != EXT_TEXT[k][p])
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        code = MIME_NONE;
        if (ext.res_len >= RES_LEN_SAT && ext.dot_seen && !ext.last_dot_at_start)
        begin
            for (int k = EXT_ENTRIES - 1; k >= 0; k--)
            begin
                if (hit[k])
                begin
                    code = EXT_CODE[k];
                end
            end
        end
    end

endmodule

@@ src/hrlp_core.sv @@
// ----------------------------------------------------------------------------
// hrlp_core
// Parse state registers and the per-byte tagging logic.
// ----------------------------------------------------------------------------
module hrlp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  hrlp_pkg::req_t item,
    output hrlp_pkg::rsp_t result
);
    import hrlp_pkg::*;

    phase_t          phase_reg,    phase_next;
    logic [3:0]      mlen_reg,     mlen_next;
    logic            match_reg,    match_next;
    logic [2:0]      rlen_reg,     rlen_next;
    logic            dot_reg,      dot_next;
    logic            ldot_reg,     ldot_next;
    logic [2:0]      elen_reg,     elen_next;
    logic [3:0]      field_reg,    field_next;
    logic            ovf_reg,      ovf_next;
    logic [3:0][7:0] ext_chars_reg;

    // current state as seen by this byte: start of request forces reset values
    phase_t     ph;
    logic [3:0] mlen;
    logic       match;
    logic [2:0] rlen;
    logic       dot;
    logic       ldot;
    logic [2:0] elen;
    logic [3:0] field;
    logic       ovf;

    logic [7:0] b;
    logic [7:0] lower;
    logic       ext_wr;
    logic       get_now;
    ext_info_t  ext;
    mime_t      mime;

    assign b     = item.req_byte;
    assign lower = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? (b | CASE_BIT) : b;

    always_comb
    begin
        if (item.start_of_request)
        begin
            ph    = PH_METHOD;
            mlen  = '0;
            match = 1'b1;
            rlen  = '0;
            dot   = 1'b0;
            ldot  = 1'b0;
            elen  = '0;
            field = '0;
            ovf   = 1'b0;
        end
        else
        begin
            ph    = phase_reg;
            mlen  = mlen_reg;
            match = match_reg;
            rlen  = rlen_reg;
            dot   = dot_reg;
            ldot  = ldot_reg;
            elen  = elen_reg;
            field = field_reg;
            ovf   = ovf_reg;
        end
    end

    assign get_now = match && (mlen == GET_LEN);

    assign ext.res_len           = rlen;
    assign ext.dot_seen          = dot;
    assign ext.last_dot_at_start = ldot;
    assign ext.ext_len           = elen;
    assign ext.ext_chars         = ext_chars_reg;

    hrlp_mime u_mime (
        .ext  (ext),
        .code (mime)
    );

    always_comb
    begin
        phase_next = ph;
        mlen_next  = mlen;
        match_next = match;
        rlen_next  = rlen;
        dot_next   = dot;
        ldot_next  = ldot;
        elen_next  = elen;
        field_next = field;
        ovf_next   = ovf;
        ext_wr     = 1'b0;
        result     = '0;

        unique case (ph)
            PH_METHOD:
            begin
                if (b == CHAR_SPACE)
                begin
                    result.byte_role = ROLE_SKIP;
                    phase_next       = PH_SLASH;
                end
                else
                begin
                    result.byte_role = ROLE_METHOD;
                    if (mlen >= GET_LEN || mlen >= METHOD_LIMIT
                        || b != GET_WORD[mlen[1:0]])
                    begin
                        match_next = 1'b0;
                    end
                    if (mlen != METHOD_SAT)
                    begin
                        mlen_next = mlen + 4'd1;
                    end
                end
            end
            PH_SLASH:
            begin
                if (get_now)
                begin
                    result.byte_role = ROLE_SKIP;
                    phase_next       = PH_RESOURCE;
                end
                else
                begin
                    // not GET: the line closes here with nothing collected
                    result.byte_role      = ROLE_LINE_END;
                    result.line_done      = 1'b1;
                    result.resource_empty = (rlen == '0);
                    result.client_side    = (rlen == '0) || dot;
                    result.mime_code      = mime;
                    result.field_overflow = ovf;
                    phase_next            = PH_DONE;
                end
            end
            PH_RESOURCE:
            begin
                if (b == CHAR_SPACE)
                begin
                    result.byte_role      = ROLE_LINE_END;
                    result.line_done      = 1'b1;
                    result.is_get         = get_now;
                    result.resource_empty = (rlen == '0);
                    result.client_side    = (rlen == '0) || dot;
                    result.mime_code      = mime;
                    result.field_overflow = ovf;
                    phase_next            = PH_DONE;
                end
                else if (b == CHAR_QMARK)
                begin
                    result.byte_role = ROLE_QUERY;
                    phase_next       = PH_QUERY;
                end
                else
                begin
                    result.byte_role = ROLE_RESOURCE;
                    if (b == CHAR_DOT)
                    begin
                        dot_next  = 1'b1;
                        ldot_next = (rlen == '0);
                        elen_next = '0;
                    end
                    else
                    begin
                        ext_wr = (elen < EXT_STORE);
                        if (elen != EXT_LEN_SAT)
                        begin
                            elen_next = elen + 3'd1;
                        end
                    end
                    if (rlen != RES_LEN_SAT)
                    begin
                        rlen_next = rlen + 3'd1;
                    end
                end
            end
            PH_QUERY:
            begin
                if (b == CHAR_SPACE)
                begin
                    result.byte_role      = ROLE_LINE_END;
                    result.line_done      = 1'b1;
                    result.is_get         = get_now;
                    result.resource_empty = (rlen == '0);
                    result.client_side    = (rlen == '0) || dot;
                    result.mime_code      = mime;
                    result.field_count    = {1'b0, field} + 5'd1;
                    result.field_overflow = ovf;
                    phase_next            = PH_DONE;
                end
                else if (b == CHAR_AMP)
                begin
                    result.byte_role = ROLE_SEPARATOR;
                    if (field != FIELD_LAST)
                    begin
                        field_next = field + 4'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    result.byte_role   = ROLE_FIELD;
                    result.field_index = field;
                end
            end
            default:
            begin
                result.byte_role = ROLE_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            mlen_reg  <= '0;
            match_reg <= 1'b1;
            rlen_reg  <= '0;
            dot_reg   <= 1'b0;
            ldot_reg  <= 1'b0;
            elen_reg  <= '0;
            field_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            mlen_reg  <= mlen_next;
            match_reg <= match_next;
            rlen_reg  <= rlen_next;
            dot_reg   <= dot_next;
            ldot_reg  <= ldot_next;
            elen_reg  <= elen_next;
            field_reg <= field_next;
            ovf_reg   <= ovf_next;
        end
    end

    // extension characters are only read below the written length
    always_ff @(posedge clk)
    begin
        if (step_en && ext_wr)
        begin
            ext_chars_reg[elen[1:0]] <= lower;
        end
    end

endmodule

@@ src/http_request_line_parser.sv @@
// ----------------------------------------------------------------------------
// http_request_line_parser
// Tags each byte of an HTTP request line and summarizes the line at its end.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one byte per
//   transaction; start_of_request on a byte restarts parsing with that byte.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) gives one result per byte,
//   in order: byte role, field index, and on the line-end byte the GET flag,
//   resource summary, MIME code and query field count.
//   Pipeline: two register stages (input register, then result register);
//   an accepted byte waits in the input register, and its result is
//   registered in the result register and presented from then on.
//   Throughput: one byte per cycle while the rsp channel does not stall,
//   limited by the single parse-state update per byte.
//   Stall: while rsp_ready is low the result holds and one more byte can sit
//   in the input register; req_ready drops only when both are full.
//   Reset: rst_n clears both stages and returns the parser to the method
//   phase.
// ----------------------------------------------------------------------------
`include "http_request_line_parser_macros.svh"

module http_request_line_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hrlp_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output hrlp_pkg::rsp_t rsp_data
);
    import hrlp_pkg::*;

    logic s1_valid_reg;
    req_t s1_data_reg;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;
    rsp_t step_result;
    logic advance;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    hrlp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (s1_data_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_data_reg <= req_data;
        end
        if (advance)
        begin
            rsp_data_reg <= step_result;
        end
    end

    `HRLP_ASSERT_IMP(a_done_is_line_end, rsp_valid_reg, rsp_data_reg.line_done == (rsp_data_reg.byte_role == ROLE_LINE_END), "line_done disagrees with byte role")
    `HRLP_ASSERT_IMP(a_summary_zero, rsp_valid_reg && !rsp_data_reg.line_done, rsp_data_reg.field_count == 5'd0 && rsp_data_reg.mime_code == MIME_NONE && !rsp_data_reg.is_get, "line summary set without line end")
    `HRLP_ASSERT_IMP(a_overflow_count, rsp_valid_reg && rsp_data_reg.field_overflow, rsp_data_reg.field_count == 5'(MAX_FIELDS), "overflow without saturated field count")
    `HRLP_ASSERT_NEXT(a_held_byte_kept, s1_valid_reg && rsp_valid_reg && !rsp_ready, s1_valid_reg && $stable(s1_data_reg), "buffered byte lost during stall")

endmodule

@@ verif/http_request_line_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_line_parser_test
// Feeds request lines one byte per transaction and follows the parse with an
// in-bench model. Every result is checked field by field against the oldest
// pending prediction. Directed lines come first: each MIME extension, empty
// and odd methods, query overflow, zero bytes, restarts and ignored bytes.
// Random lines follow, mostly well formed, with some noise. Both handshakes
// stall at random.
// ----------------------------------------------------------------------------
module http_request_line_parser_test;
    import hrlp_pkg::*;

    localparam int          RANDOM_BYTES = 440;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          STALL_PCT    = 31;
    localparam logic [7:0]  CHAR_SLASH   = 8'h2F;
    localparam logic [23:0] GET_TEXT     = "GET";

    // Predicts the parser result for each accepted byte and checks results in order.
    class request_line_scoreboard;
        rsp_t       expected_results[$];
        int         errors;
        phase_t     phase;
        logic [3:0] method_len;
        logic       method_is_get;
        logic [2:0] resource_len;
        logic       dot_seen;
        logic       dot_at_start;
        logic [7:0] ext_chars[4];
        logic [2:0] ext_len;
        logic [4:0] field_no;
        logic       overflow;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase         = PH_METHOD;
            method_len    = '0;
            method_is_get = 1'b1;
            resource_len  = '0;
            dot_seen      = 1'b0;
            dot_at_start  = 1'b0;
            foreach (ext_chars[i])
                ext_chars[i] = '0;
            ext_len       = '0;
            field_no      = '0;
            overflow      = 1'b0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function mime_t extension_mime();
            logic [31:0] ext_word;
            ext_word = '0;
            if (resource_len < 3'd4 || !dot_seen || dot_at_start)
                return MIME_NONE;
            for (int i = 0; i < 4; i++)
                if (i < ext_len)
                    ext_word[31 - 8 * i -: 8] = ext_chars[i];
            case ({ext_len, ext_word})
                {3'd4, "html"}:        return MIME_HTML;
                {3'd3, "css", 8'h00}:  return MIME_CSS;
                {3'd2, "js", 16'h0}:   return MIME_JS;
                {3'd3, "bmp", 8'h00}:  return MIME_BMP;
                {3'd4, "jpeg"}:        return MIME_JPEG;
                {3'd3, "jpg", 8'h00}:  return MIME_JPEG;
                {3'd3, "png", 8'h00}:  return MIME_PNG;
                {3'd4, "webp"}:        return MIME_WEBP;
                {3'd3, "ico", 8'h00}:  return MIME_ICO;
                default:               return MIME_NONE;
            endcase
        endfunction

        function rsp_t line_summary(logic query_seen);
            rsp_t r;
            r                = '0;
            r.byte_role      = ROLE_LINE_END;
            r.line_done      = 1'b1;
            r.is_get         = method_is_get && method_len == 4'd3;
            r.resource_empty = resource_len == 3'd0;
            r.client_side    = resource_len == 3'd0 || dot_seen;
            r.mime_code      = extension_mime();
            r.field_count    = query_seen ? field_no + 5'd1 : 5'd0;
            r.field_overflow = overflow;
            phase            = PH_DONE;
            return r;
        endfunction

        function void note_request(req_t req);
            rsp_t       want;
            logic [7:0] b;
            logic [7:0] c;
            b = req.req_byte;
            if (req.start_of_request)
                restart();
            want = '0;
            case (phase)
                PH_METHOD:
                    if (b == CHAR_SPACE)
                    begin
                        want.byte_role = ROLE_SKIP;
                        phase = PH_SLASH;
                    end
                    else
                    begin
                        want.byte_role = ROLE_METHOD;
                        if (method_len >= 4'd3 || method_len >= MAX_METHOD_LEN
                            || b != GET_TEXT[8 * (2 - method_len) +: 8])
                            method_is_get = 1'b0;
                        if (method_len != 4'hF)
                            method_len++;
                    end
                PH_SLASH:
                    if (method_is_get && method_len == 4'd3)
                    begin
                        want.byte_role = ROLE_SKIP;
                        phase = PH_RESOURCE;
                    end
                    else
                        want = line_summary(1'b0);
                PH_RESOURCE:
                    if (b == CHAR_SPACE)
                        want = line_summary(1'b0);
                    else if (b == CHAR_QMARK)
                    begin
                        want.byte_role = ROLE_QUERY;
                        phase = PH_QUERY;
                    end
                    else
                    begin
                        want.byte_role = ROLE_RESOURCE;
                        if (b == CHAR_DOT)
                        begin
                            dot_seen     = 1'b1;
                            dot_at_start = resource_len == 3'd0;
                            ext_len      = '0;
                        end
                        else
                        begin
                            c = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? (b | CASE_BIT) : b;
                            if (ext_len < 3'd4)
                                ext_chars[ext_len[1:0]] = c;
                            if (ext_len < 3'd5)
                                ext_len++;
                        end
                        if (resource_len < 3'd4)
                            resource_len++;
                    end
                PH_QUERY:
                    if (b == CHAR_SPACE)
                        want = line_summary(1'b1);
                    else if (b == CHAR_AMP)
                    begin
                        want.byte_role = ROLE_SEPARATOR;
                        if (int'(field_no) + 1 < MAX_FIELDS)
                            field_no++;
                        else
                            overflow = 1'b1;
                    end
                    else
                    begin
                        want.byte_role   = ROLE_FIELD;
                        want.field_index = field_no[3:0];
                    end
                default:
                    want.byte_role = ROLE_IGNORED;
            endcase
            expected_results.push_back(want);
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.byte_role !== want.byte_role)
                flag("byte_role", want.byte_role, got.byte_role);
            if (got.field_index !== want.field_index)
                flag("field_index", want.field_index, got.field_index);
            if (got.line_done !== want.line_done)
                flag("line_done", want.line_done, got.line_done);
            if (got.is_get !== want.is_get)
                flag("is_get", want.is_get, got.is_get);
            if (got.resource_empty !== want.resource_empty)
                flag("resource_empty", want.resource_empty, got.resource_empty);
            if (got.client_side !== want.client_side)
                flag("client_side", want.client_side, got.client_side);
            if (got.mime_code !== want.mime_code)
                flag("mime_code", want.mime_code, got.mime_code);
            if (got.field_count !== want.field_count)
                flag("field_count", want.field_count, got.field_count);
            if (got.field_overflow !== want.field_overflow)
                flag("field_overflow", want.field_overflow, got.field_overflow);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp_data;
    bit          calm      = 1'b0;
    int unsigned cycle_count = 0;
    logic [7:0]  line_bytes[$];

    request_line_scoreboard sb = new();

    http_request_line_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
    end

    // both transactions of one edge are handled here, so order within the step is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req_data);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte_except(logic [7:0] a, logic [7:0] c);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == a || b == c);
        return b;
    endfunction

    function automatic logic [7:0] resource_char();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(8'h7A, 8'h61));
            4, 5:       return 8'($urandom_range(CHAR_UP_Z, CHAR_UP_A));
            6:          return 8'($urandom_range(8'h39, 8'h30));
            7:          return CHAR_DOT;
            8:          return CHAR_SLASH;
            default:    return any_byte_except(CHAR_SPACE, CHAR_QMARK);
        endcase
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic void add_mixed_case(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1)
                c = c ^ CASE_BIT;
            line_bytes.push_back(c);
        end
    endfunction

    // Builds one line in line_bytes; returns the byte count before trailing bytes.
    function automatic int build_random_line();
        string exts[10] = '{"html", "css", "js", "bmp", "jpeg", "jpg", "png",
                            "webp", "ico", "txt"};
        string odd_methods[4] = '{"GE", "GETS", "HEAD", "PUT"};
        int    n;
        int    fields;
        int    counted;
        line_bytes.delete();
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(20, 1);
            repeat (n)
                line_bytes.push_back($urandom_range(3) == 0 ? CHAR_SPACE
                                                             : 8'($urandom_range(255)));
            return n;
        end
        case ($urandom_range(11))
            0, 1, 2, 3, 4, 5, 6: add_text("GET");
            7:                   add_text("POST");
            8:                   add_mixed_case("get");
            9:                   add_text(odd_methods[$urandom_range(3)]);
            10:
            begin
                n = $urandom_range(17, 4);
                repeat (n)
                    line_bytes.push_back(8'($urandom_range(CHAR_UP_Z, CHAR_UP_A)));
            end
            default: ;
        endcase
        line_bytes.push_back(CHAR_SPACE);
        line_bytes.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) : CHAR_SLASH);
        n = ($urandom_range(1) == 1) ? $urandom_range(5) : $urandom_range(8);
        repeat (n)
            line_bytes.push_back(resource_char());
        if ($urandom_range(1) == 1)
        begin
            line_bytes.push_back(CHAR_DOT);
            add_mixed_case(exts[$urandom_range(9)]);
        end
        if ($urandom_range(99) < 40)
        begin
            line_bytes.push_back(CHAR_QMARK);
            fields = ($urandom_range(9) < 8) ? $urandom_range(5) : $urandom_range(20, 14);
            for (int f = 0; f < fields; f++)
            begin
                if (f > 0)
                    line_bytes.push_back(CHAR_AMP);
                repeat ($urandom_range(4))
                    line_bytes.push_back(any_byte_except(CHAR_SPACE, CHAR_AMP));
            end
        end
        if ($urandom_range(99) < 85)
            line_bytes.push_back(CHAR_SPACE);
        counted = line_bytes.size();
        // bytes after the line end are only tagged as ignored
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1))
                line_bytes.push_back(8'($urandom_range(255)));
        return counted;
    endfunction

    // Entered and left at a falling edge; valid stays high after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic sor);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < STALL_PCT)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{req_byte: b, start_of_request: sor};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_line(input logic sor_first);
        foreach (line_bytes[i])
            send_byte(line_bytes[i], (i == 0) ? sor_first : ($urandom_range(99) == 0));
    endtask

    task automatic directed_line(input string s);
        line_bytes.delete();
        add_text(s);
        send_line(1'b1);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int random_bytes;
        int line_no;
        random_bytes = 0;
        line_no      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // the first line fills all four extension slots
        directed_line("GET /a.html ");
        directed_line("GET /STYLE.CSS?x=1&y=2 ");
        directed_line("GET /s.Js ");
        directed_line("GET /i.BMP ");
        directed_line("GET /p.jpeg ");
        directed_line("GET /p.JPG ");
        directed_line("GET /p.png ");
        directed_line("GET /p.WebP ");
        directed_line("GET /f.ico ");
        directed_line("GET / xx");
        directed_line("GET /.png ");
        directed_line("GET /a.b ");
        directed_line("GET /abcd ");
        directed_line("GET /x.htmlx ");
        directed_line("POST /index.html ");
        directed_line(" /a ");
        directed_line("GETTINGLONGMETHOD /a ");
        directed_line("GET /q? ");
        line_bytes.delete();
        add_text("GET /q?");
        repeat (18) add_text("a&");
        add_text("b ");
        send_line(1'b1);
        line_bytes.delete();
        add_text("GET /");
        line_bytes.push_back(8'h00);
        add_text("a.c");
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h00);
        add_text("?");
        line_bytes.push_back(8'h00);
        add_text(" ");
        send_line(1'b1);
        line_bytes.delete();
        line_bytes.push_back(8'h00);
        add_text("GET /x ");
        send_line(1'b1);
        // restart in the middle of a line
        directed_line("GET /abc");
        directed_line("GET /z.css ");
        wait_for_drain();

        while (random_bytes < RANDOM_BYTES)
        begin
            calm = (line_no >= 6 && line_no < 14);
            random_bytes += build_random_line();
            send_line($urandom_range(19) != 0);
            if (line_no % 12 == 11)
                wait_for_drain();
            line_no++;
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
